// ===== rtl/core/gsa_pkg.sv =====
// Shared types and codes for the growable slot allocator.
package gsa_pkg;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_ERASE   = 2'd1,
		CMD_SHRINK  = 2'd2,
		CMD_REBUILD = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_BAD_ERASE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POP,
		ST_GROW,
		ST_ERASE,
		ST_SCAN,
		ST_HALVE,
		ST_REBUILD,
		ST_RESP
	} state_t;

	// Write enables toward the three stores.
	typedef struct packed {
		logic occ;
		logic stk;
		logic store;
	} mem_we_t;

endpackage

// ===== rtl/core/gsa_if.sv =====
// Request and response channel interfaces of the slot allocator.
interface gsa_req_if #(
	parameter int SLOT_W      = 10,
	parameter int ENTRY_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             command;
	logic [SLOT_W-1:0]      target_slot;
	logic [ENTRY_WIDTH-1:0] entry_value;

	modport source (output valid, command, target_slot, entry_value, input ready);
	modport sink   (input valid, command, target_slot, entry_value, output ready);
endinterface

interface gsa_rsp_if #(
	parameter int SLOT_W = 10,
	parameter int CAP_W  = 11
);
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot_number;
	logic [1:0]        status;
	logic [CAP_W-1:0]  capacity_now;

	modport source (output valid, slot_number, status, capacity_now, input ready);
	modport sink   (input valid, slot_number, status, capacity_now, output ready);
endinterface

// ===== rtl/core/growable_slot_allocator_core.sv =====
// Growable slot allocator: a handle table handing out slots from a LIFO free stack.
// Channels: req carries command, target_slot and entry_value; rsp returns
// slot_number, status and capacity_now, one word for every request word.
// Both use valid/ready; a word moves on a clock edge with valid and ready high.
// Once arst_n is released the block clears its occupancy store, one slot per cycle,
// over all MAX_SLOTS slots; req.ready stays low until that pass ends. Capacity is
// then one with slot 0 free.
// After acceptance: an add from the free stack passes ST_POP, an erase ST_ERASE,
// an add with growth walks the new slots in ST_GROW, a failed growth goes straight
// to ST_RESP, rebuild runs ST_REBUILD and shrink runs ST_SCAN, ST_HALVE, ST_REBUILD.
// The free-stack rebuild and the occupancy scan step one slot per cycle through
// the single read port of the occupancy RAM.
// One request is in flight at a time; req.ready returns in the cycle after the
// response leaves the sequencer.
// The response sits in an output register, so a new request is taken while a
// finished response waits; if rsp stalls, the following request finishes and
// holds until the register drains.
module growable_slot_allocator_core #(
	parameter int MAX_SLOTS   = 1024,
	parameter int ENTRY_WIDTH = 32,
	localparam int SLOT_W     = $clog2(MAX_SLOTS),
	localparam int CAP_W      = $clog2(MAX_SLOTS + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	gsa_req_if.sink   req,
	gsa_rsp_if.source rsp
);
	import gsa_pkg::*;

	mem_we_t                mem_we;
	logic [SLOT_W-1:0]      occ_waddr;
	logic                   occ_wdata;
	logic [SLOT_W-1:0]      occ_raddr;
	logic                   occ_rdata;
	logic [SLOT_W-1:0]      stk_waddr;
	logic [SLOT_W-1:0]      stk_wdata;
	logic [SLOT_W-1:0]      stk_raddr;
	logic [SLOT_W-1:0]      stk_rdata;
	logic [ENTRY_WIDTH-1:0] store_wdata;
	logic                   rsp_valid;
	logic                   rsp_ack;
	logic [SLOT_W-1:0]      rsp_slot;
	status_t                rsp_status;
	logic [CAP_W-1:0]       rsp_capacity;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [1:0]        out_status_q;
	logic [CAP_W-1:0]  out_cap_q;

	gsa_ctrl #(
		.MAX_SLOTS   (MAX_SLOTS),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.command      (cmd_t'(req.command)),
		.target_slot  (req.target_slot),
		.entry_value  (req.entry_value),
		.mem_we       (mem_we),
		.occ_waddr    (occ_waddr),
		.occ_wdata    (occ_wdata),
		.occ_raddr    (occ_raddr),
		.occ_rdata    (occ_rdata),
		.stk_waddr    (stk_waddr),
		.stk_wdata    (stk_wdata),
		.stk_raddr    (stk_raddr),
		.stk_rdata    (stk_rdata),
		.store_wdata  (store_wdata),
		.rsp_valid    (rsp_valid),
		.rsp_ack      (rsp_ack),
		.rsp_slot     (rsp_slot),
		.rsp_status   (rsp_status),
		.rsp_capacity (rsp_capacity)
	);

	gsa_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_occ_ram (
		.clk   (clk),
		.we    (mem_we.occ),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.raddr (occ_raddr),
		.rdata (occ_rdata)
	);

	gsa_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_stk_ram (
		.clk   (clk),
		.we    (mem_we.stk),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// entry words are kept for the host side; nothing here reads them back
	gsa_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(MAX_SLOTS)) u_store_ram (
		.clk   (clk),
		.we    (mem_we.store),
		.waddr (occ_waddr),
		.wdata (store_wdata),
		.raddr ('0),
		.rdata ()
	);

	assign rsp_ack = rsp_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ack) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ack) begin
			out_slot_q   <= rsp_slot;
			out_status_q <= rsp_status;
			out_cap_q    <= rsp_capacity;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.slot_number  = out_slot_q;
	assign rsp.status       = out_status_q;
	assign rsp.capacity_now = out_cap_q;

endmodule

// ===== rtl/core/gsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gsa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/gsa_ctrl.sv =====
// Sequencer and shared index/compare datapath of the slot allocator.
module gsa_ctrl #(
	parameter int MAX_SLOTS   = 1024,
	parameter int ENTRY_WIDTH = 32,
	localparam int SLOT_W     = $clog2(MAX_SLOTS),
	localparam int CAP_W      = $clog2(MAX_SLOTS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  gsa_pkg::cmd_t          command,
	input  logic [SLOT_W-1:0]      target_slot,
	input  logic [ENTRY_WIDTH-1:0] entry_value,
	output gsa_pkg::mem_we_t       mem_we,
	output logic [SLOT_W-1:0]      occ_waddr,
	output logic                   occ_wdata,
	output logic [SLOT_W-1:0]      occ_raddr,
	input  logic                   occ_rdata,
	output logic [SLOT_W-1:0]      stk_waddr,
	output logic [SLOT_W-1:0]      stk_wdata,
	output logic [SLOT_W-1:0]      stk_raddr,
	input  logic [SLOT_W-1:0]      stk_rdata,
	output logic [ENTRY_WIDTH-1:0] store_wdata,
	output logic                   rsp_valid,
	input  logic                   rsp_ack,
	output logic [SLOT_W-1:0]      rsp_slot,
	output gsa_pkg::status_t       rsp_status,
	output logic [CAP_W-1:0]       rsp_capacity
);
	import gsa_pkg::*;

	state_t                 state_q, state_d;
	logic [CAP_W-1:0]       cap_q;
	logic [CAP_W-1:0]       fc_q;
	logic [CAP_W-1:0]       idx_q;
	logic                   pend_q;
	logic [SLOT_W-1:0]      rd_idx_q;
	logic [SLOT_W-1:0]      highest_q;
	logic [SLOT_W-1:0]      target_q;
	logic [ENTRY_WIDTH-1:0] value_q;
	logic [SLOT_W-1:0]      slot_q;
	status_t                status_q;

	logic             accept;
	logic [CAP_W:0]   new_cap;
	logic             grow_ok;
	logic             fc_room;
	logic             push;
	logic             push_ok;
	logic [SLOT_W-1:0] push_slot;
	logic             grow_more;
	logic             erase_ok;
	logic             shrink_more;
	logic             scan_more;
	logic [CAP_W-1:0] idx_dec;
	logic [CAP_W-1:0] fc_dec;

	assign accept      = in_valid && in_ready;
	assign new_cap     = {cap_q, 1'b0};
	assign grow_ok     = new_cap <= (CAP_W + 1)'(MAX_SLOTS);
	assign fc_room     = fc_q < CAP_W'(MAX_SLOTS);
	assign push_ok     = push && fc_room;
	assign grow_more   = idx_q > CAP_W'(slot_q);
	assign erase_ok    = (CAP_W'(target_q) < cap_q) && (CAP_W'(target_q) < CAP_W'(MAX_SLOTS))
		&& occ_rdata;
	assign shrink_more = (cap_q >> 1) > CAP_W'(highest_q);
	assign scan_more   = idx_q < cap_q;
	assign idx_dec     = idx_q - 1'b1;
	assign fc_dec      = fc_q - 1'b1;

	assign rsp_slot     = slot_q;
	assign rsp_status   = status_q;
	assign rsp_capacity = cap_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (idx_q == CAP_W'(MAX_SLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_ADD: begin
							if (fc_q != '0) state_d = ST_POP;
							else if (grow_ok) state_d = ST_GROW;
							else state_d = ST_RESP;
						end
						CMD_ERASE:   state_d = ST_ERASE;
						CMD_SHRINK:  state_d = ST_SCAN;
						CMD_REBUILD: state_d = ST_REBUILD;
					endcase
				end
			end
			ST_POP:   state_d = ST_RESP;
			ST_GROW: begin
				if (!grow_more) state_d = ST_RESP;
			end
			ST_ERASE: state_d = ST_RESP;
			ST_SCAN: begin
				if (!scan_more && !pend_q) state_d = ST_HALVE;
			end
			ST_HALVE: begin
				if (!shrink_more) state_d = ST_REBUILD;
			end
			ST_REBUILD: begin
				if (idx_q == '0 && !pend_q) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_ack) state_d = ST_IDLE;
			end
		endcase
	end

	// memory controls and handshake
	always_comb begin
		in_ready    = 1'b0;
		rsp_valid   = 1'b0;
		mem_we      = '0;
		occ_waddr   = slot_q;
		occ_wdata   = 1'b1;
		occ_raddr   = idx_q[SLOT_W-1:0];
		store_wdata = value_q;
		push        = 1'b0;
		push_slot   = rd_idx_q;
		stk_raddr   = fc_dec[SLOT_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we.occ = 1'b1;
				occ_waddr  = idx_q[SLOT_W-1:0];
				occ_wdata  = 1'b0;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				occ_raddr = target_slot;
			end
			ST_POP: begin
				mem_we.occ   = 1'b1;
				mem_we.store = 1'b1;
				occ_waddr    = stk_rdata;
			end
			ST_GROW: begin
				mem_we.occ   = 1'b1;
				mem_we.store = 1'b1;
				push         = grow_more;
				push_slot    = idx_q[SLOT_W-1:0];
			end
			ST_ERASE: begin
				mem_we.occ   = erase_ok;
				mem_we.store = erase_ok;
				occ_waddr    = target_q;
				occ_wdata    = 1'b0;
				store_wdata  = '0;
				push         = erase_ok;
				push_slot    = target_q;
			end
			ST_SCAN: begin
				occ_raddr = idx_q[SLOT_W-1:0];
			end
			ST_HALVE: begin
			end
			ST_REBUILD: begin
				occ_raddr = idx_dec[SLOT_W-1:0];
				push      = pend_q && !occ_rdata;
			end
			ST_RESP: begin
				rsp_valid = 1'b1;
			end
		endcase
		// the clearing pass also leaves stack entry i = i, so entry 0 holds slot 0
		if (state_q == ST_CLEAR) begin
			mem_we.stk = 1'b1;
			stk_waddr  = idx_q[SLOT_W-1:0];
			stk_wdata  = idx_q[SLOT_W-1:0];
		end else begin
			mem_we.stk = push && fc_room;
			stk_waddr  = fc_q[SLOT_W-1:0];
			stk_wdata  = push_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cap_q   <= CAP_W'(1);
			fc_q    <= CAP_W'(1);
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: idx_q <= idx_q + 1'b1;
				ST_IDLE: begin
					if (accept) begin
						pend_q <= 1'b0;
						unique case (command)
							CMD_ADD: begin
								if (fc_q == '0 && grow_ok) begin
									cap_q <= new_cap[CAP_W-1:0];
									idx_q <= new_cap[CAP_W-1:0] - 1'b1;
								end
							end
							CMD_ERASE: ;
							// stack is rebuilt after halving, so drop it now
							CMD_SHRINK: begin
								idx_q <= '0;
								fc_q  <= '0;
							end
							CMD_REBUILD: begin
								idx_q <= cap_q;
								fc_q  <= '0;
							end
						endcase
					end
				end
				ST_POP: fc_q <= fc_dec;
				ST_GROW: begin
					idx_q <= idx_dec;
					if (push_ok) fc_q <= fc_q + 1'b1;
				end
				ST_ERASE: begin
					if (push_ok) fc_q <= fc_q + 1'b1;
				end
				ST_SCAN: begin
					pend_q <= scan_more;
					if (scan_more) idx_q <= idx_q + 1'b1;
				end
				ST_HALVE: begin
					if (shrink_more) begin
						cap_q <= cap_q >> 1;
					end else begin
						idx_q  <= cap_q;
						fc_q   <= '0;
						pend_q <= 1'b0;
					end
				end
				ST_REBUILD: begin
					pend_q <= idx_q != '0;
					if (idx_q != '0) idx_q <= idx_dec;
					if (push_ok) fc_q <= fc_q + 1'b1;
				end
				ST_RESP: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					target_q  <= target_slot;
					value_q   <= entry_value;
					slot_q    <= '0;
					status_q  <= STATUS_OK;
					highest_q <= '0;
					if (command == CMD_ADD && fc_q == '0) begin
						if (grow_ok) slot_q <= cap_q[SLOT_W-1:0];
						else status_q <= STATUS_FULL;
					end
				end
			end
			ST_POP: slot_q <= stk_rdata;
			ST_ERASE: begin
				if (!erase_ok) status_q <= STATUS_BAD_ERASE;
			end
			ST_SCAN: begin
				if (pend_q && occ_rdata) highest_q <= rd_idx_q;
				rd_idx_q <= idx_q[SLOT_W-1:0];
			end
			ST_REBUILD: rd_idx_q <= idx_dec[SLOT_W-1:0];
			ST_CLEAR, ST_GROW, ST_HALVE, ST_RESP: ;
		endcase
	end

`ifndef SYNTH
	a_fc_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= cap_q)
		else $error("free count exceeds capacity");

	a_cap_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(cap_q))
		else $error("capacity is not a power of two");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (fc_q != '0))
		else $error("pop from an empty free stack");

	a_full_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status_q == STATUS_FULL) |-> (fc_q == '0 && slot_q == '0))
		else $error("full status with free slots left");

	a_shrink_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HALVE && state_d == ST_REBUILD) |-> (CAP_W'(highest_q) < cap_q))
		else $error("shrink dropped an occupied slot");
`endif

endmodule
